// ----- sv/xcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// xcpf_pkg
// Shared types and constants of the framer: byte slots of a frame, register
// indexes and the command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package xcpf_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOOTER = 1'd1;

   // reset values of the registers
   localparam logic [BYTE_WIDTH-1:0] HEADER_RESET = 8'h0B;
   localparam logic [BYTE_WIDTH-1:0] FOOTER_RESET = 8'h0E;

   // front end phase codes
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [1:0] PHASE_SWALLOW = 2'd2;

   // byte slots of a frame, in wire order
   localparam int          NUM_SLOTS   = 5;
   localparam logic [2:0]  SLOT_HEADER = 3'd0;
   localparam logic [2:0]  SLOT_LENGTH = 3'd1;
   localparam logic [2:0]  SLOT_DATA   = 3'd2;
   localparam logic [2:0]  SLOT_CHECK  = 3'd3;
   localparam logic [2:0]  SLOT_FOOTER = 3'd4;

   // command queue
   localparam int QUEUE_DEPTH = 2;

   // one command: which slots go out, and the bytes they carry
   typedef struct packed {
      logic                  has_head;   // header and length byte
      logic                  has_data;   // one payload byte
      logic                  has_close;  // checksum and footer
      logic [BYTE_WIDTH-1:0] length;
      logic [BYTE_WIDTH-1:0] data;
      logic [BYTE_WIDTH-1:0] check;
   } cmd_type;

   // queue head status seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ----- sv/xcpf_front.sv -----
// ----------------------------------------------------------------------------
// xcpf_front
// Request front end: tracks the packet phase, folds the checksum and turns
// each accepted request into at most one command for the back end.
// ----------------------------------------------------------------------------
module xcpf_front #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           start_req,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0] packet_length,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0] data_byte,
   output logic                           push,
   output xcpf_pkg::cmd_type              cmd
);

   localparam logic [xcpf_pkg::BYTE_WIDTH-1:0] MAX_LEN = xcpf_pkg::BYTE_WIDTH'(MAX_PAYLOAD);

   logic [1:0]                        phase_ff, phase_in;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]   remain_ff, remain_in;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]   check_ff, check_in;

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      check_in  = check_ff;
      push      = 1'b0;
      cmd       = '0;
      cmd.length = packet_length;
      cmd.data   = data_byte;
      if (accept) begin
         priority if (start_req) begin
            if (packet_length > MAX_LEN) begin
               // oversize: drop the packet, swallow its later bytes
               check_in  = '0;
               phase_in  = xcpf_pkg::PHASE_SWALLOW;
               remain_in = packet_length - 8'd1;
            end else begin
               push         = 1'b1;
               cmd.has_head = 1'b1;
               if (packet_length == 8'd0) begin
                  cmd.has_close = 1'b1;
                  check_in      = packet_length;
                  phase_in      = xcpf_pkg::PHASE_IDLE;
                  remain_in     = '0;
               end else begin
                  cmd.has_data = 1'b1;
                  check_in     = packet_length ^ data_byte;
                  if (packet_length == 8'd1) begin
                     cmd.has_close = 1'b1;
                     phase_in      = xcpf_pkg::PHASE_IDLE;
                     remain_in     = '0;
                  end else begin
                     phase_in  = xcpf_pkg::PHASE_PAYLOAD;
                     remain_in = packet_length - 8'd1;
                  end
               end
            end
         end else if (phase_ff == xcpf_pkg::PHASE_PAYLOAD) begin
            push         = 1'b1;
            cmd.has_data = 1'b1;
            check_in     = check_ff ^ data_byte;
            remain_in    = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               cmd.has_close = 1'b1;
               phase_in      = xcpf_pkg::PHASE_IDLE;
            end
         end else if (phase_ff == xcpf_pkg::PHASE_SWALLOW) begin
            remain_in = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               phase_in = xcpf_pkg::PHASE_IDLE;
            end
         end else begin
            phase_in = xcpf_pkg::PHASE_IDLE;
         end
      end
      cmd.check = check_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= xcpf_pkg::PHASE_IDLE;
         remain_ff <= '0;
         check_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         check_ff  <= check_in;
      end
   end

   // a packet in progress always expects at least one more byte
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == xcpf_pkg::PHASE_PAYLOAD |-> remain_ff != '0)
      else $error("payload phase with no bytes remaining");

endmodule

// ----- sv/xcpf_queue.sv -----
// ----------------------------------------------------------------------------
// xcpf_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module xcpf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xcpf_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output logic               full,
   output xcpf_pkg::head_type head
);

   localparam int PTR_WIDTH = $clog2(xcpf_pkg::QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(xcpf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(xcpf_pkg::QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(xcpf_pkg::QUEUE_DEPTH - 1);

   xcpf_pkg::cmd_type     slot_ff [xcpf_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_WIDTH'(do_push) - CNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("command popped from empty queue");

endmodule

// ----- sv/xcpf_back.sv -----
// ----------------------------------------------------------------------------
// xcpf_back
// Frame back end: walks the byte slots of the head command and drives one
// framed byte per cycle into the output register while the result side does not stall.
// ----------------------------------------------------------------------------
module xcpf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  xcpf_pkg::head_type              head,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0] header_byte,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0] footer_byte,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [xcpf_pkg::BYTE_WIDTH-1:0] rsp_out_byte,
   output logic                            rsp_frame_end
);

   logic [2:0]                        slot_ff, slot_in;
   logic                              valid_ff, valid_in;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]   byte_ff, byte_in;
   logic                              end_ff, end_in;

   logic                              load;
   logic [xcpf_pkg::NUM_SLOTS-1:0]    present;
   logic [xcpf_pkg::NUM_SLOTS-1:0]    cand;
   logic [xcpf_pkg::NUM_SLOTS-1:0]    rest;
   logic [2:0]                        pick;
   logic                              found;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]   pick_byte;

   assign load = !valid_ff || !rsp_stall;

   assign present = {head.cmd.has_close, head.cmd.has_close, head.cmd.has_data,
                     head.cmd.has_head, head.cmd.has_head};

   // first slot of the head command at or after the current position
   always_comb begin
      pick  = xcpf_pkg::SLOT_HEADER;
      found = 1'b0;
      rest  = '0;
      for (int i = 0; i < xcpf_pkg::NUM_SLOTS; i++) begin
         cand[i] = present[i] && (3'(i) >= slot_ff);
      end
      for (int i = 0; i < xcpf_pkg::NUM_SLOTS; i++) begin
         if (cand[i] && !found) begin
            pick  = 3'(i);
            found = 1'b1;
         end else if (cand[i]) begin
            rest[i] = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (pick)
         xcpf_pkg::SLOT_HEADER: pick_byte = header_byte;
         xcpf_pkg::SLOT_LENGTH: pick_byte = head.cmd.length;
         xcpf_pkg::SLOT_DATA:   pick_byte = head.cmd.data;
         xcpf_pkg::SLOT_CHECK:  pick_byte = head.cmd.check;
         default:               pick_byte = footer_byte;
      endcase
   end

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            byte_in = pick_byte;
            end_in  = (pick == xcpf_pkg::SLOT_FOOTER);
            if (rest == '0) begin
               pop     = 1'b1;
               slot_in = xcpf_pkg::SLOT_HEADER;
            end else begin
               slot_in = pick + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= xcpf_pkg::SLOT_HEADER;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;

   // a partly sent command stays at the queue head until its last byte
   a_mid_command_head: assert property (@(posedge clock) disable iff (reset)
      slot_ff != xcpf_pkg::SLOT_HEADER |-> head.valid)
      else $error("command position set with empty queue");

endmodule

// ----- sv/xor_checked_packet_framer_top.sv -----
// ----------------------------------------------------------------------------
// xor_checked_packet_framer_top
// Length-prefixed packet framer with XOR checksum, one byte per result.
// ----------------------------------------------------------------------------
// The framer takes one request and sends one byte per cycle when not stalled.
// A start request opens a frame and yields header, length and (for a nonzero
// length) the first payload byte, plus checksum and footer when the packet is
// that short: three to five result bytes. Each later payload request yields one
// byte, and the last one also the checksum and footer: one or three bytes.
// Oversize packets, idle data and the rest of a dropped packet give nothing.
// The front end classifies each request in the cycle it is accepted and writes
// a command into a two-entry queue; the back end drains the head command one
// byte slot per cycle unless stalled, via a registered output stage. Requests
// thus go one per cycle while the result side keeps up, and the output byte
// rate, one per cycle, sets the pace once frame overhead piles up in the queue.
// Header and footer bytes are programmable through the csr_ port; write them
// only while no frame is in flight.
// ----------------------------------------------------------------------------
module xor_checked_packet_framer_top #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_packet_length,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [xcpf_pkg::BYTE_WIDTH-1:0]      rsp_out_byte,
   output logic                                 rsp_frame_end,
   // register write port
   input  logic                                 csr_write,
   input  logic [xcpf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      csr_data
);

   logic [xcpf_pkg::BYTE_WIDTH-1:0] header_ff, header_in;
   logic [xcpf_pkg::BYTE_WIDTH-1:0] footer_ff, footer_in;

   logic               req_accept;
   logic               push;
   logic               pop;
   logic               full;
   xcpf_pkg::cmd_type  push_cmd;
   xcpf_pkg::head_type head;

   // Hold the request side while the command queue has no room.
   assign req_stall  = full;
   assign req_accept = req_valid && !req_stall;

   // Register writes: header and footer bytes.
   always_comb begin
      header_in = header_ff;
      footer_in = footer_ff;
      if (csr_write) begin
         unique case (csr_index)
            xcpf_pkg::CSR_HEADER: header_in = csr_data;
            xcpf_pkg::CSR_FOOTER: footer_in = csr_data;
            default:              header_in = header_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= xcpf_pkg::HEADER_RESET;
         footer_ff <= xcpf_pkg::FOOTER_RESET;
      end else begin
         header_ff <= header_in;
         footer_ff <= footer_in;
      end
   end

   // Front end: phase tracking, checksum, command build.
   xcpf_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .start_req     (req_start_req),
      .packet_length (req_packet_length),
      .data_byte     (req_data_byte),
      .push          (push),
      .cmd           (push_cmd)
   );

   // Decouple the two sides so each can stall on its own.
   xcpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   // Back end: advance through byte slots, one result per cycle unless stalled.
   xcpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .header_byte   (header_ff),
      .footer_byte   (footer_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ----- tb/xcpf_frame_checker.sv -----
// ----------------------------------------------------------------------------
// xcpf_frame_checker
// Watches the request, result and register ports of the framer, predicts the
// framed byte stream and compares every accepted result against it.
// ----------------------------------------------------------------------------
module xcpf_frame_checker #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_packet_length,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      rsp_out_byte,
   input  logic                                 rsp_frame_end,
   input  logic                                 csr_write,
   input  logic [xcpf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [xcpf_pkg::BYTE_WIDTH-1:0]      csr_data,
   output int                                   mismatch_count,
   output int                                   bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [xcpf_pkg::BYTE_WIDTH-1:0] value;
      logic                            last;
   } wire_byte_type;

   wire_byte_type                   wire_bytes_q[$];
   logic [xcpf_pkg::BYTE_WIDTH-1:0] header_reg;
   logic [xcpf_pkg::BYTE_WIDTH-1:0] footer_reg;
   logic [xcpf_pkg::BYTE_WIDTH-1:0] bytes_left;
   logic [xcpf_pkg::BYTE_WIDTH-1:0] xor_sum;
   logic [1:0]                      frame_phase;

   task automatic emit_byte(input logic [xcpf_pkg::BYTE_WIDTH-1:0] value,
                            input logic last);
      wire_byte_type b;
      b.value = value;
      b.last  = last;
      wire_bytes_q.push_back(b);
   endtask

   task automatic close_frame();
      emit_byte(xor_sum, 1'b0);
      emit_byte(footer_reg, 1'b1);
      frame_phase = xcpf_pkg::PHASE_IDLE;
      bytes_left  = '0;
   endtask

   // Advance the framer state by one request and queue the bytes it sends.
   task automatic frame_request(input logic start,
                                input logic [xcpf_pkg::BYTE_WIDTH-1:0] len,
                                input logic [xcpf_pkg::BYTE_WIDTH-1:0] data);
      if (start) begin
         if (len > MAX_PAYLOAD) begin
            // oversize: drop the packet, swallow the rest of its bytes
            xor_sum     = '0;
            frame_phase = xcpf_pkg::PHASE_SWALLOW;
            bytes_left  = len - 1'b1;
         end else begin
            emit_byte(header_reg, 1'b0);
            emit_byte(len, 1'b0);
            xor_sum = len;
            if (len == '0) begin
               close_frame();
            end else begin
               emit_byte(data, 1'b0);
               xor_sum = xor_sum ^ data;
               if (len == 8'd1) begin
                  close_frame();
               end else begin
                  frame_phase = xcpf_pkg::PHASE_PAYLOAD;
                  bytes_left  = len - 1'b1;
               end
            end
         end
      end else if (frame_phase == xcpf_pkg::PHASE_PAYLOAD) begin
         emit_byte(data, 1'b0);
         xor_sum    = xor_sum ^ data;
         bytes_left = bytes_left - 1'b1;
         if (bytes_left == '0) close_frame();
      end else if (frame_phase == xcpf_pkg::PHASE_SWALLOW) begin
         bytes_left = bytes_left - 1'b1;
         if (bytes_left == '0) frame_phase = xcpf_pkg::PHASE_IDLE;
      end else begin
         frame_phase = xcpf_pkg::PHASE_IDLE;
      end
   endtask

   task automatic check_byte(input logic [xcpf_pkg::BYTE_WIDTH-1:0] value,
                             input logic last);
      wire_byte_type want;
      if (wire_bytes_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected byte %02h end=%0b", $realtime, value, last);
      end else begin
         want = wire_bytes_q.pop_front();
         if (value !== want.value || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: byte mismatch, expected %02h end=%0b, got %02h end=%0b",
                        $realtime, want.value, want.last, value, last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         header_reg  = xcpf_pkg::HEADER_RESET;
         footer_reg  = xcpf_pkg::FOOTER_RESET;
         frame_phase = xcpf_pkg::PHASE_IDLE;
         bytes_left  = '0;
         xor_sum     = '0;
         wire_bytes_q.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == xcpf_pkg::CSR_HEADER)
               header_reg = csr_data;
            else if (csr_index == xcpf_pkg::CSR_FOOTER)
               footer_reg = csr_data;
         end
         if (req_valid && !req_stall)
            frame_request(req_start_req, req_packet_length, req_data_byte);
         if (rsp_valid && !rsp_stall)
            check_byte(rsp_out_byte, rsp_frame_end);
      end
      bytes_outstanding = wire_bytes_q.size();
   end

endmodule

// ----- tb/xor_checked_packet_framer_top_tb.sv -----
// ----------------------------------------------------------------------------
// xor_checked_packet_framer_top_tb
// Drives framed packets, broken packets, oversize drops and idle noise into the
// framer under random back pressure; a checker beside the block predicts and
// compares every framed byte, and this module gives the verdict.
// ----------------------------------------------------------------------------
module xor_checked_packet_framer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD     = 64;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 16;
   localparam int ITEMS_PER_PHASE = 77;
   localparam int LIMIT_CYCLES    = 400000;

   typedef logic [xcpf_pkg::BYTE_WIDTH-1:0] byte_type;

   logic                                 clock             = 1'b0;
   logic                                 reset             = 1'b1;
   logic                                 req_valid         = 1'b0;
   logic                                 req_start_req     = 1'b0;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_packet_length = '0;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]      req_data_byte     = '0;
   logic                                 rsp_stall         = 1'b0;
   logic                                 csr_write         = 1'b0;
   logic [xcpf_pkg::CSR_INDEX_WIDTH-1:0] csr_index         = xcpf_pkg::CSR_HEADER;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]      csr_data          = '0;
   logic                                 req_stall;
   logic                                 rsp_valid;
   logic [xcpf_pkg::BYTE_WIDTH-1:0]      rsp_out_byte;
   logic                                 rsp_frame_end;

   int send_idle_pct  = 9;
   int recv_stall_pct = 62;
   int cycle_count    = 0;
   int items_sent     = 0;
   int mismatch_count;
   int bytes_outstanding;

   xor_checked_packet_framer_top #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_packet_length (req_packet_length),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   xcpf_frame_checker #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_packet_length (req_packet_length),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   always #10 clock = ~clock;

   // Random back pressure on the result side; the percentage follows the phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog: abort a run that hangs on a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Present one request and hold it until the framer takes it. Valid stays
   // high on return so that a back-to-back request never toggles it; the next
   // call drops it only when it chooses to idle. Stall is read at the falling
   // edge, where it already holds the value the next rising edge will see.
   task automatic send_request(input logic start, input byte_type len,
                               input byte_type data);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_req     <= start;
      req_packet_length <= len;
      req_data_byte     <= data;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // Open a packet of the given length and follow it with payload_items more
   // payload requests; fewer than length-1 leaves the packet unfinished.
   task automatic send_packet(input byte_type len, input int payload_items);
      send_request(1'b1, len, byte_type'($urandom));
      for (int i = 0; i < payload_items; i++)
         send_request(1'b0, byte_type'($urandom), byte_type'($urandom));
   endtask

   // Hold the request side until every expected byte is out, then let the
   // back end run dry before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (bytes_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program header and footer on back-to-back edges; call only when drained.
   task automatic write_frame_bytes(input byte_type header, input byte_type footer);
      csr_write <= 1'b1;
      csr_index <= xcpf_pkg::CSR_HEADER;
      csr_data  <= header;
      @(posedge clock);
      csr_index <= xcpf_pkg::CSR_FOOTER;
      csr_data  <= footer;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int kind;
      int len;
      int n;
      int target;
      bit midway_done;

      midway_done = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset header/footer values ---
      send_request(1'b1, 8'd0, 8'hA5);      // zero length: bare frame
      send_request(1'b1, 8'd1, 8'hFF);      // length one: whole frame at once
      send_request(1'b1, 8'd2, 8'h00);
      send_request(1'b0, 8'hFF, 8'hFF);     // length field ignored mid-packet
      send_request(1'b0, 8'h55, 8'h33);     // data while idle: dropped
      drain();

      // --- directed: programmed extremes ---
      write_frame_bytes(8'h00, 8'hFF);
      send_packet(8'd3, 1);                 // left unfinished ...
      send_request(1'b1, 8'd0, 8'h5A);      // ... abandoned by a new start
      send_request(1'b1, 8'hFF, 8'h7F);     // largest length: dropped
      send_request(1'b0, 8'h12, 8'hC3);     // swallowed
      send_request(1'b1, 8'd1, 8'h42);      // start during the swallow
      send_request(1'b1, byte_type'(MAX_PAYLOAD + 1), 8'h99); // just above the limit
      send_request(1'b0, 8'h00, 8'h01);
      send_packet(8'd2, 1);                 // start while still swallowing
      send_packet(8'd4, 3);

      // --- random phases: sender/receiver idle rates and header/footer vary ---
      for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
         drain();
         unique case (phase_idx)
            0: begin
               send_idle_pct  = 9;
               recv_stall_pct = 62;
               write_frame_bytes(8'hFF, 8'h00);
            end
            1: begin
               send_idle_pct  = 62;
               recv_stall_pct = 9;
               write_frame_bytes(byte_type'($urandom), byte_type'($urandom));
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_frame_bytes(byte_type'($urandom), byte_type'($urandom));
            end
         endcase

         // one maximum-length packet and one fully swallowed drop per run
         if (phase_idx == 0) begin
            send_packet(byte_type'(MAX_PAYLOAD), MAX_PAYLOAD - 1);
         end else if (phase_idx == 1) begin
            send_packet(byte_type'(MAX_PAYLOAD + 1), MAX_PAYLOAD);
            send_packet(8'd3, 2);
         end

         target = ITEMS_PER_PHASE * (phase_idx + 1);
         while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 78) begin
               // well-formed packet, mostly short
               n = $urandom_range(99);
               if (n < 65)
                  len = $urandom_range(6);
               else if (n < 92)
                  len = $urandom_range(20, 7);
               else
                  len = $urandom_range(MAX_PAYLOAD, 21);
               send_packet(byte_type'(len), (len == 0) ? 0 : len - 1);
            end else if (kind < 86) begin
               // broken packet: stop short, the next start abandons it
               len = $urandom_range(20, 2);
               n   = $urandom_range(len - 2);
               send_packet(byte_type'(len), n);
            end else if (kind < 92) begin
               // stray data requests; payload if a packet is still open
               n = $urandom_range(3, 1);
               for (int i = 0; i < n; i++)
                  send_request(1'b0, byte_type'($urandom), byte_type'($urandom));
            end else if (kind < 97) begin
               // oversize drop, swallowed fully or cut off by the next start;
               // cut the long ones off early to keep the run short
               len = ($urandom_range(3) != 0) ? $urandom_range(80, MAX_PAYLOAD + 1)
                                              : $urandom_range(255, 81);
               n   = (len <= 80 && $urandom_range(1) != 0) ? len - 1
                                                           : $urandom_range(3);
               send_packet(byte_type'(len), n);
            end else begin
               drain();
            end

            // pause the sender once mid-run until the framer has caught up
            if (!midway_done && items_sent >= ITEMS_PER_PHASE / 2) begin
               midway_done = 1;
               drain();
            end
         end
      end

      drain();
      if (mismatch_count == 0 && bytes_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
